[hdl/mct_pkg.sv]
// Shared types, format codes and the level size arithmetic for the mip chain trim planner.
// No dependencies; every other file of the block imports this package.
package mct_pkg;

  localparam int MAX_MIPS_DEF = 15;
  localparam int SIDE_W = 15;
  localparam int MIPS_W = 4;
  localparam int FMT_W = 3;
  localparam int LVL_BYTES_W = 34;
  localparam int SAVED_W = 32;
  localparam logic [SIDE_W-1:0] MIN_DIM_RESET = 15'd4;

  localparam logic [FMT_W-1:0] FMT_PLAIN32 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_BC4 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_BC8 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_PLAIN64 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_PLAIN8 = 3'd4;

  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [MIPS_W-1:0] mip_levels;
    logic [FMT_W-1:0]  format_class;
  } texture_t;

  function automatic logic is_bc(input logic [FMT_W-1:0] fc);
    return (fc == FMT_BC4) || (fc == FMT_BC8);
  endfunction

  // Bytes of one level. Block formats count 4x4 blocks, plain formats count texels;
  // both become one 15x15 product followed by a shift for the bytes per unit.
  function automatic logic [LVL_BYTES_W-1:0] level_bytes(input logic [FMT_W-1:0] fc,
                                                         input logic [SIDE_W-1:0] w,
                                                         input logic [SIDE_W-1:0] h);
    logic [SIDE_W-1:0] a;
    logic [SIDE_W-1:0] b;
    logic [2*SIDE_W-1:0] p;
    logic [2:0] sh;
    if (is_bc(fc)) begin
      a = SIDE_W'((({1'b0, w}) + 16'd3) >> 2);
      b = SIDE_W'((({1'b0, h}) + 16'd3) >> 2);
    end else begin
      a = w;
      b = h;
    end
    case (fc)
      FMT_BC4:     sh = 3'd3;
      FMT_BC8:     sh = 3'd4;
      FMT_PLAIN64: sh = 3'd3;
      FMT_PLAIN8:  sh = 3'd0;
      default:     sh = 3'd2;
    endcase
    p = a * b;
    return LVL_BYTES_W'(p) << sh;
  endfunction

  function automatic logic [SAVED_W-1:0] sat_add(input logic [SAVED_W-1:0] acc,
                                                 input logic [LVL_BYTES_W-1:0] add);
    logic [LVL_BYTES_W:0] sum;
    sum = {{(LVL_BYTES_W-SAVED_W+1){1'b0}}, acc} + {1'b0, add};
    if (sum[LVL_BYTES_W:SAVED_W] != '0) begin
      return '1;
    end
    return sum[SAVED_W-1:0];
  endfunction

endpackage

[hdl/mct_skip_plan.sv]
// Three register stages that decide how many top mip levels an item drops.
// Depends on mct_pkg for the texture struct and the format helpers.
module mct_skip_plan #(
  parameter int MAX_MIPS = mct_pkg::MAX_MIPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  mct_pkg::texture_t            in_tex,
  input  logic [mct_pkg::SIDE_W-1:0]   limit_size,
  input  logic [mct_pkg::SIDE_W-1:0]   min_dimension,
  output logic                         out_valid,
  output mct_pkg::texture_t            out_tex,
  output logic [$clog2(MAX_MIPS)-1:0]  out_skip
);
  import mct_pkg::*;

  localparam int NL = MAX_MIPS - 1;
  localparam int SKW = $clog2(MAX_MIPS);

  logic a_valid;
  texture_t a_tex;
  logic [NL-1:0] a_cond;
  logic [NL-1:0] a_cond_next;

  logic b_valid;
  texture_t b_tex;
  logic [SKW-1:0] b_skip;
  logic [SKW-1:0] b_skip_next;
  logic [NL:1] b_align;
  logic [NL:1] b_align_next;

  logic [SKW-1:0] c_skip_next;

  // Each halving step is tested on its own; the chain keeps the leading run of passes.
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      a_cond_next[k] = (limit_size != '0) &&
                       (((in_tex.width >> k) > limit_size) ||
                        ((in_tex.height >> k) > limit_size)) &&
                       ((k + 1) < int'(in_tex.mip_levels)) &&
                       ((in_tex.width >> (k + 1)) >= min_dimension) &&
                       ((in_tex.height >> (k + 1)) >= min_dimension);
    end
  end

  always_comb begin
    logic [SIDE_W-1:0] ws;
    logic [SIDE_W-1:0] hs;
    b_skip_next = SKW'(NL);
    for (int k = NL - 1; k >= 0; k--) begin
      if (!a_cond[k]) begin
        b_skip_next = SKW'(k);
      end
    end
    for (int s = 1; s <= NL; s++) begin
      ws = a_tex.width >> s;
      hs = a_tex.height >> s;
      b_align_next[s] = (ws[1:0] == 2'b00) && (hs[1:0] == 2'b00);
    end
  end

  // Block formats back off to the deepest aligned level not past the halving result.
  always_comb begin
    if (is_bc(b_tex.format_class)) begin
      c_skip_next = '0;
      for (int s = 1; s <= NL; s++) begin
        if ((s <= int'(b_skip)) && b_align[s]) begin
          c_skip_next = SKW'(s);
        end
      end
    end else begin
      c_skip_next = b_skip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tex <= in_tex;
      a_cond <= a_cond_next;
      b_tex <= a_tex;
      b_skip <= b_skip_next;
      b_align <= b_align_next;
      out_tex <= b_tex;
      out_skip <= c_skip_next;
    end
  end

endmodule

[hdl/mct_level_stage.sv]
// One stage of the saved-bytes chain: sizes one mip level and adds the previous level's size.
// Depends on mct_pkg for the texture struct, level_bytes and sat_add.
module mct_level_stage #(
  parameter int MAX_MIPS = mct_pkg::MAX_MIPS_DEF,
  parameter int LEVEL = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  mct_pkg::texture_t                 in_tex,
  input  logic [$clog2(MAX_MIPS)-1:0]       in_skip,
  input  logic [mct_pkg::LVL_BYTES_W-1:0]   in_prod,
  input  logic [mct_pkg::SAVED_W-1:0]       in_acc,
  output logic                              out_valid,
  output mct_pkg::texture_t                 out_tex,
  output logic [$clog2(MAX_MIPS)-1:0]       out_skip,
  output logic [mct_pkg::LVL_BYTES_W-1:0]   out_prod,
  output logic [mct_pkg::SAVED_W-1:0]       out_acc
);
  import mct_pkg::*;

  logic [LVL_BYTES_W-1:0] prod_next;

  // Only dropped levels count toward the saving.
  always_comb begin
    if (LEVEL < int'(in_skip)) begin
      prod_next = level_bytes(in_tex.format_class, in_tex.width >> LEVEL,
                              in_tex.height >> LEVEL);
    end else begin
      prod_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tex <= in_tex;
      out_skip <= in_skip;
      out_prod <= prod_next;
      out_acc <= sat_add(in_acc, in_prod);
    end
  end

endmodule

[hdl/mip_chain_trim_planner_unit.sv]
// Top level of the mip chain trim planner: skip planning, the per-level byte chain and the
// result register. Depends on mct_pkg, mct_skip_plan and mct_level_stage.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_stall   width, height, mip_levels, format_class, limit_size
//   out      out_valid / out_stall skip_count, new_width, new_height, new_mip_levels,
//                                  saved_bytes
//   cfg      cfg_write             cfg_data -> min_dimension
//
// One item enters per cycle while the pipeline does not hold, and its result passes through
// the stages: three stages plan the skip count, one stage per possibly dropped level sizes
// that level with its own 15x15 multiplier, and the last stage adds in the final level.
// A synchronous rst clears every valid bit and sets min_dimension to 4.
// The whole pipeline holds when the result register is full and out_stall is high; in that
// cycle in_stall is high too, so no item is lost or taken twice.
module mip_chain_trim_planner_unit #(
  parameter int MAX_MIPS = mct_pkg::MAX_MIPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [mct_pkg::SIDE_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mct_pkg::SIDE_W-1:0]     width,
  input  logic [mct_pkg::SIDE_W-1:0]     height,
  input  logic [mct_pkg::MIPS_W-1:0]     mip_levels,
  input  logic [mct_pkg::FMT_W-1:0]      format_class,
  input  logic [mct_pkg::SIDE_W-1:0]     limit_size,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mct_pkg::MIPS_W-1:0]     skip_count,
  output logic [mct_pkg::SIDE_W-1:0]     new_width,
  output logic [mct_pkg::SIDE_W-1:0]     new_height,
  output logic [mct_pkg::MIPS_W-1:0]     new_mip_levels,
  output logic [mct_pkg::SAVED_W-1:0]    saved_bytes
);
  import mct_pkg::*;

  // NL levels can be dropped at most, so the byte chain has NL stages.
  localparam int NL = MAX_MIPS - 1;
  localparam int SKW = $clog2(MAX_MIPS);

  logic [SIDE_W-1:0] min_dimension;
  logic adv;
  texture_t in_tex;

  // Index i of these arrays is the input of byte stage i; index NL feeds the result register.
  logic [NL:0] st_valid;
  texture_t st_tex [NL+1];
  logic [SKW-1:0] st_skip [NL+1];
  logic [LVL_BYTES_W-1:0] st_prod [NL+1];
  logic [SAVED_W-1:0] st_acc [NL+1];

  // The pipeline moves unless a finished result is waiting on a stalled receiver.
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign in_tex.width = width;
  assign in_tex.height = height;
  assign in_tex.mip_levels = mip_levels;
  assign in_tex.format_class = format_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dimension <= MIN_DIM_RESET;
    end else if (cfg_write) begin
      min_dimension <= cfg_data;
    end
  end

  mct_skip_plan #(
    .MAX_MIPS(MAX_MIPS)
  ) u_skip_plan (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(in_valid),
    .in_tex(in_tex),
    .limit_size(limit_size),
    .min_dimension(min_dimension),
    .out_valid(st_valid[0]),
    .out_tex(st_tex[0]),
    .out_skip(st_skip[0])
  );

  // The chain starts with nothing summed and no pending level size.
  assign st_prod[0] = '0;
  assign st_acc[0] = '0;

  for (genvar g = 0; g < NL; g++) begin : g_level
    mct_level_stage #(
      .MAX_MIPS(MAX_MIPS),
      .LEVEL(g)
    ) u_level (
      .clk(clk),
      .rst(rst),
      .adv(adv),
      .in_valid(st_valid[g]),
      .in_tex(st_tex[g]),
      .in_skip(st_skip[g]),
      .in_prod(st_prod[g]),
      .in_acc(st_acc[g]),
      .out_valid(st_valid[g+1]),
      .out_tex(st_tex[g+1]),
      .out_skip(st_skip[g+1]),
      .out_prod(st_prod[g+1]),
      .out_acc(st_acc[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= st_valid[NL];
    end
  end

  // The result register also adds the last level's size and applies the skip to the sides.
  always_ff @(posedge clk) begin
    if (adv) begin
      skip_count <= MIPS_W'(st_skip[NL]);
      new_width <= st_tex[NL].width >> st_skip[NL];
      new_height <= st_tex[NL].height >> st_skip[NL];
      new_mip_levels <= st_tex[NL].mip_levels - MIPS_W'(st_skip[NL]);
      saved_bytes <= sat_add(st_acc[NL], st_prod[NL]);
    end
  end

endmodule

[dv/mip_chain_trim_planner_unit_test.sv]
// Self-checking testbench for mip_chain_trim_planner_unit: directed corner textures, then
// random texture streams under several min_dimension settings with random idling on both sides.
// Depends on mct_pkg and the mip_chain_trim_planner_unit RTL.
module mip_chain_trim_planner_unit_test;
  import mct_pkg::*;

  // Format codes that the block does not define; it must treat them as plain 32 bpp.
  localparam logic [FMT_W-1:0] FMT_SPARE5 = 3'd5;
  localparam logic [FMT_W-1:0] FMT_SPARE6 = 3'd6;
  localparam logic [FMT_W-1:0] FMT_SPARE7 = 3'd7;

  // Largest value of the 32-bit byte estimate; the sum saturates here.
  localparam longint unsigned SAVED_CEIL = 64'hFFFF_FFFF;

  // One expected result item.
  typedef struct {
    logic [MIPS_W-1:0]  skip;
    logic [SIDE_W-1:0]  w;
    logic [SIDE_W-1:0]  h;
    logic [MIPS_W-1:0]  mips;
    logic [SAVED_W-1:0] saved;
  } trim_plan_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write;
  logic [SIDE_W-1:0]   cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [SIDE_W-1:0]   width;
  logic [SIDE_W-1:0]   height;
  logic [MIPS_W-1:0]   mip_levels;
  logic [FMT_W-1:0]    format_class;
  logic [SIDE_W-1:0]   limit_size;
  logic                out_valid;
  logic                out_stall;
  logic [MIPS_W-1:0]   skip_count;
  logic [SIDE_W-1:0]   new_width;
  logic [SIDE_W-1:0]   new_height;
  logic [MIPS_W-1:0]   new_mip_levels;
  logic [SAVED_W-1:0]  saved_bytes;

  // Plans still owed by the block, oldest first.
  trim_plan_t  plan_q[$];
  // Our copy of the min_dimension register.
  logic [SIDE_W-1:0] min_side;
  // When set, neither side idles, so items go through back to back.
  bit          quiet;

  int n_err;
  int n_items;
  int n_results;
  int n_trimmed;
  int n_saturated;
  int n_settings;

  mip_chain_trim_planner_unit uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .width          (width),
    .height         (height),
    .mip_levels     (mip_levels),
    .format_class   (format_class),
    .limit_size     (limit_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .skip_count     (skip_count),
    .new_width      (new_width),
    .new_height     (new_height),
    .new_mip_levels (new_mip_levels),
    .saved_bytes    (saved_bytes)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Plans the trim of one texture. Both sides are halved together while either side is
  // over the limit, one level at least stays, the chain bound is respected and neither
  // half drops below min_side. Block-compressed formats then give back levels until the
  // first kept level is 4-aligned on both axes. The byte estimate sums every dropped
  // level and saturates at the 32-bit ceiling.
  function automatic trim_plan_t plan_trim(input logic [SIDE_W-1:0] w0,
                                           input logic [SIDE_W-1:0] h0,
                                           input logic [MIPS_W-1:0] mips,
                                           input logic [FMT_W-1:0]  fc,
                                           input logic [SIDE_W-1:0] lim);
    trim_plan_t      p;
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
    int unsigned     skip;
    int unsigned     l;
    longint unsigned lw;
    longint unsigned lh;
    longint unsigned lvl;
    longint unsigned bits;
    longint unsigned total;
    bit              bc;
    bc = (fc == FMT_BC4) || (fc == FMT_BC8);
    skip = 0;
    total = 0;
    if (lim != 0 && (w0 > lim || h0 > lim)) begin
      w = w0;
      h = h0;
      while ((w > lim || h > lim) && skip + 1 < mips && skip + 1 < MAX_MIPS_DEF &&
             (w >> 1) >= min_side && (h >> 1) >= min_side) begin
        w = w >> 1;
        h = h >> 1;
        skip++;
      end
      if (bc) begin
        while (skip > 0 && (((w0 >> skip) & 3) != 0 || ((h0 >> skip) & 3) != 0))
          skip--;
      end
    end
    for (l = 0; l < skip; l++) begin
      lw = w0 >> l;
      lh = h0 >> l;
      if (bc) begin
        lvl = ((lw + 3) / 4) * ((lh + 3) / 4) * ((fc == FMT_BC4) ? 8 : 16);
      end else begin
        case (fc)
          FMT_PLAIN64: bits = 64;
          FMT_PLAIN8:  bits = 8;
          default:     bits = 32;
        endcase
        lvl = (lw * lh * bits) / 8;
      end
      total = total + lvl;
      if (total > SAVED_CEIL) total = SAVED_CEIL;
    end
    p.skip = skip[MIPS_W-1:0];
    p.w = w0 >> skip;
    p.h = h0 >> skip;
    p.mips = mips - skip[MIPS_W-1:0];
    p.saved = total[SAVED_W-1:0];
    return p;
  endfunction

  // Idle length for either side: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A side length that favors powers of two and multiples of 4, since those are what
  // real textures use and what the block-compressed alignment rule cares about. A tenth
  // of the time it covers the whole 15-bit field, beyond the nominal largest side.
  function automatic logic [SIDE_W-1:0] rand_side();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return SIDE_W'(1 << $urandom_range(0, 14));
    if (r < 65) return SIDE_W'($urandom_range(1, 4096) * 4);
    if (r < 90) return SIDE_W'($urandom_range(1, 16384));
    return SIDE_W'($urandom_range(0, 32767));
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (n_err < 100)
      $display("ERROR: %s: got %0d, expected %0d (result %0d)", what, got, want, n_results);
    n_err++;
  endtask

  // Offers one texture item after a random gap and holds it until the block takes it.
  // The valid stays high on return, so a following item with no gap goes straight on.
  task automatic send_item(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                           input logic [MIPS_W-1:0] m, input logic [FMT_W-1:0] fc,
                           input logic [SIDE_W-1:0] lim);
    int gap;
    trim_plan_t p;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    width <= w;
    height <= h;
    mip_levels <= m;
    format_class <= fc;
    limit_size <= lim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = plan_trim(w, h, m, fc, lim);
    plan_q.push_back(p);
    n_items++;
    if (p.skip != 0) n_trimmed++;
    if (p.saved == '1) n_saturated++;
  endtask

  // Stops offering items and waits until every owed result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (plan_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // The register is only written while nothing is in flight.
  task automatic set_min_side(input logic [SIDE_W-1:0] v);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    min_side = v;
    n_settings++;
  endtask

  // A zero limit, sides already within the limit, a zero mip count and zero sides all
  // leave the texture untouched.
  task automatic test_untouched();
    send_item(15'd16384, 15'd16384, 4'd15, FMT_PLAIN32, 15'd0);
    send_item(15'd300, 15'd200, 4'd9, FMT_BC4, 15'd300);
    send_item(15'd4096, 15'd4096, 4'd0, FMT_PLAIN32, 15'd16);
    send_item(15'd0, 15'd0, 4'd1, FMT_PLAIN8, 15'd5);
    send_item(15'h7FFF, 15'h7FFF, 4'd15, FMT_PLAIN64, 15'h7FFF);
    send_item(15'd1, 15'd1, 4'd1, FMT_BC8, 15'd1);
  endtask

  // Plain halving for every plain format and the spare codes, a chain that runs out of
  // levels, and a top level large enough to push the byte estimate to its ceiling.
  task automatic test_plain_halving();
    send_item(15'd2048, 15'd2048, 4'd12, FMT_PLAIN32, 15'd512);
    send_item(15'd4096, 15'd1024, 4'd13, FMT_PLAIN64, 15'd1000);
    send_item(15'd1000, 15'd3000, 4'd12, FMT_PLAIN8, 15'd100);
    send_item(15'd4096, 15'd4096, 4'd3, FMT_PLAIN32, 15'd16);
    send_item(15'd1024, 15'd1024, 4'd11, FMT_SPARE5, 15'd64);
    send_item(15'd512, 15'd512, 4'd10, FMT_SPARE6, 15'd8);
    send_item(15'd256, 15'd128, 4'd9, FMT_SPARE7, 15'd100);
    send_item(15'h7FFF, 15'h7FFF, 4'd15, FMT_PLAIN64, 15'd1);
  endtask

  // Block-compressed textures: a partial back-off, a back-off all the way to the top
  // level, a deep aligned trim and a strongly non-square texture.
  task automatic test_block_alignment();
    send_item(15'd40, 15'd24, 4'd6, FMT_BC4, 15'd10);
    send_item(15'd24, 15'd20, 4'd5, FMT_BC8, 15'd5);
    send_item(15'd16384, 15'd16384, 4'd15, FMT_BC4, 15'd4);
    send_item(15'd16384, 15'd12, 4'd15, FMT_BC8, 15'd1000);
  endtask

  // The register at its extremes: zero leaves only the limit and the chain bound to stop the
  // halving, the largest values stop all halving, and one lets sides go down to a single texel.
  task automatic test_min_side_extremes();
    set_min_side(15'd0);
    send_item(15'd16384, 15'd16384, 4'd15, FMT_PLAIN32, 15'd1);
    send_item(15'd0, 15'd5000, 4'd14, FMT_PLAIN32, 15'd100);
    set_min_side(15'h7FFF);
    send_item(15'd16384, 15'd16384, 4'd15, FMT_PLAIN32, 15'd16);
    set_min_side(15'd16384);
    send_item(15'd16384, 15'd16384, 4'd15, FMT_PLAIN32, 15'd1);
    set_min_side(15'd1);
    send_item(15'd16384, 15'd2, 4'd15, FMT_BC4, 15'd64);
    set_min_side(MIN_DIM_RESET);
  endtask

  // Random textures under one register setting. Most carry a full mip chain and a limit
  // below their size, so the halving loop really runs; the rest are odd chains, spare
  // format codes and limits of any kind. Halfway through, the sender waits for the block
  // to empty before going on.
  task automatic test_random_stream(input logic [SIDE_W-1:0] side, input int count);
    int i;
    int unsigned r;
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
    logic [SIDE_W-1:0] big;
    logic [SIDE_W-1:0] lim;
    logic [MIPS_W-1:0] m;
    logic [FMT_W-1:0]  fc;
    int unsigned       chain;
    set_min_side(side);
    for (i = 0; i < count; i++) begin
      w = rand_side();
      h = ($urandom_range(0, 99) < 30) ? w : rand_side();
      big = (w > h) ? w : h;
      chain = 0;
      while ((big >> chain) != 0) chain++;
      if (chain > MAX_MIPS_DEF) chain = MAX_MIPS_DEF;
      r = $urandom_range(0, 99);
      if (r < 70) m = MIPS_W'(chain);
      else if (r < 95) m = MIPS_W'($urandom_range(1, 15));
      else m = '0;
      fc = ($urandom_range(0, 99) < 85) ? FMT_W'($urandom_range(FMT_PLAIN32, FMT_PLAIN8))
                                        : FMT_W'($urandom_range(FMT_SPARE5, FMT_SPARE7));
      r = $urandom_range(0, 99);
      if (r < 10) lim = '0;
      else if (r < 60) lim = big >> $urandom_range(1, 8);
      else if (r < 85) lim = rand_side();
      else lim = SIDE_W'($urandom_range(1, 64));
      send_item(w, h, m, fc, lim);
      if (i == count / 2) wait_idle();
    end
  endtask

  // A burst with no idling on either side, to run the pipeline full.
  task automatic test_full_rate();
    int i;
    quiet = 1'b1;
    for (i = 0; i < 40; i++)
      send_item(rand_side(), rand_side(), MIPS_W'($urandom_range(1, 15)),
                FMT_W'($urandom_range(FMT_PLAIN32, FMT_PLAIN8)), rand_side() >> 3);
    quiet = 1'b0;
  endtask

  // The receiver stalls in random bursts, long and short, independent of the sender.
  initial begin : sink_pacing
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      n = pick_gap();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Every result the block hands over is compared, field by field, with the oldest plan.
  always @(posedge clk) begin : result_check
    trim_plan_t want;
    if (!rst && out_valid && !out_stall) begin
      if (plan_q.size() == 0) begin
        report_mismatch("result with no item outstanding", skip_count, 0);
      end else begin
        want = plan_q.pop_front();
        if (skip_count !== want.skip)
          report_mismatch("skip_count", skip_count, want.skip);
        if (new_width !== want.w)
          report_mismatch("new_width", new_width, want.w);
        if (new_height !== want.h)
          report_mismatch("new_height", new_height, want.h);
        if (new_mip_levels !== want.mips)
          report_mismatch("new_mip_levels", new_mip_levels, want.mips);
        if (saved_bytes !== want.saved)
          report_mismatch("saved_bytes", saved_bytes, want.saved);
      end
      n_results++;
    end
  end

  // A hung handshake ends the run here.
  initial begin
    #(12 * 1000000);
    $display("mip_chain_trim_planner_unit: mismatch");
    $finish;
  end

  initial begin : run
    int k;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    width <= '0;
    height <= '0;
    mip_levels <= '0;
    format_class <= '0;
    limit_size <= '0;
    min_side = MIN_DIM_RESET;
    quiet = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_untouched();
    test_plain_halving();
    test_block_alignment();
    test_min_side_extremes();
    test_full_rate();
    test_random_stream(MIN_DIM_RESET, 260);
    test_random_stream(15'd1, 260);
    test_random_stream(15'd0, 260);
    test_random_stream(15'd8, 260);
    test_random_stream(15'h7FFF, 60);
    test_random_stream(15'd16384, 60);
    test_random_stream(SIDE_W'($urandom_range(2, 64)), 260);
    test_random_stream(MIN_DIM_RESET, 260);

    // Drain with a bound, then give the pipeline its full latency to show a stray result.
    in_valid <= 1'b0;
    for (k = 0; k < 5000 && plan_q.size() != 0; k++) @(posedge clk);
    repeat (MAX_MIPS_DEF + 8) @(posedge clk);
    if (plan_q.size() != 0)
      report_mismatch("results never delivered", 0, plan_q.size());

    $display("Sent %0d textures under %0d min_dimension settings, %0d results checked.",
             n_items, n_settings, n_results);
    $display("%0d textures were trimmed and %0d reached the byte estimate ceiling.",
             n_trimmed, n_saturated);
    if (n_err == 0) begin
      $display("mip_chain_trim_planner_unit: match");
    end else begin
      $display("mip_chain_trim_planner_unit: mismatch");
    end
    $finish;
  end

endmodule

[mip_chain_trim_planner_unit.f]
hdl/mct_pkg.sv
hdl/mct_skip_plan.sv
hdl/mct_level_stage.sv
hdl/mip_chain_trim_planner_unit.sv
dv/mip_chain_trim_planner_unit_test.sv
